// File: rtl/ellipse_fan_vertex_generator_defines.svh
// Assertion macros shared by the ellipse fan vertex generator RTL.
`ifndef ELLIPSE_FAN_VERTEX_GENERATOR_DEFINES_SVH
`define ELLIPSE_FAN_VERTEX_GENERATOR_DEFINES_SVH

`ifndef SYNTH
// The condition must hold at every clock edge outside reset.
`define EFVG_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// The consequent must hold in the same cycle as the antecedent.
`define EFVG_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// The consequent must hold in the cycle after the antecedent.
`define EFVG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define EFVG_ASSERT_ALWAYS(label, cond, msg)
`define EFVG_ASSERT_IMPL(label, ante, cons, msg)
`define EFVG_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// File: rtl/efvg_pkg.sv
// Shared constants, types and arithmetic helpers of the ellipse fan vertex generator.
`default_nettype none

package efvg_pkg;

    localparam int CORDIC_STEPS_DEF = 16;

    localparam logic [5:0] MIN_POINTS = 6'd3;
    localparam logic [5:0] MAX_POINTS = 6'd62;
    localparam logic [5:0] PC_RESET   = 6'd30;

    // One quotient bit per cycle for 2^32 / n, a 33-bit dividend.
    localparam logic [5:0] DIV_STEPS = 6'd33;

    localparam logic [31:0]        QUARTER_PHASE = 32'h4000_0000;
    localparam logic signed [33:0] QUARTER_TURN  = 34'sh0_4000_0000;
    localparam logic signed [33:0] HALF_TURN     = 34'sh0_8000_0000;
    localparam logic signed [33:0] CORDIC_X0     = 34'sh0_26DD_3B6A;
    localparam logic signed [49:0] PLACE_HALF    = 50'sh4000_0000;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic cordic_start;
        logic mul_en;
        logic mul_y;
        logic px_en;
        logic out_rim;
        logic out_last;
    } efvg_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic div_done;
        logic cordic_done;
        logic out_free;
        logic idx_last_rim;
    } efvg_sts_t;

    // Rounded atan(2^-k) in binary-angle units, a full turn being 2^32.
    function automatic logic [29:0] atan_turns(input logic [4:0] k);
        logic [29:0] v;
        case (k)
            5'd0:    v = 30'd536870912;
            5'd1:    v = 30'd316933406;
            5'd2:    v = 30'd167458907;
            5'd3:    v = 30'd85004756;
            5'd4:    v = 30'd42667331;
            5'd5:    v = 30'd21354465;
            5'd6:    v = 30'd10679838;
            5'd7:    v = 30'd5340245;
            5'd8:    v = 30'd2670163;
            5'd9:    v = 30'd1335087;
            5'd10:   v = 30'd667544;
            5'd11:   v = 30'd333772;
            5'd12:   v = 30'd166886;
            5'd13:   v = 30'd83443;
            5'd14:   v = 30'd41722;
            5'd15:   v = 30'd20861;
            5'd16:   v = 30'd10430;
            5'd17:   v = 30'd5215;
            5'd18:   v = 30'd2608;
            5'd19:   v = 30'd1304;
            5'd20:   v = 30'd652;
            5'd21:   v = 30'd326;
            5'd22:   v = 30'd163;
            5'd23:   v = 30'd81;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

    // Edge plus half the size plus the scaled rim offset, rounded half up and saturated.
    function automatic logic [15:0] place(input logic signed [15:0] edge_v,
                                          input logic [14:0] size,
                                          input logic signed [49:0] prod);
        logic signed [49:0] sum;
        logic signed [18:0] q;
        logic [15:0]        r;
        sum = $signed({{3{edge_v[15]}}, edge_v, 31'b0}) + $signed({5'b0, size, 30'b0})
            + prod + PLACE_HALF;
        q = sum[49:31];
        if (q > 19'sd32767) begin
            r = 16'h7FFF;
        end
        else if (q < -19'sd32768) begin
            r = 16'h8000;
        end
        else begin
            r = q[15:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: rtl/ellipse_fan_vertex_generator.sv
// Top level of the ellipse triangle-fan vertex generator.
// The first vertex to leave after the input transaction is the center; each rim vertex then
// waits on the iterative CORDIC unit, and a busy output register can stall the sequence.
// Reset is asynchronous, active low; point_count returns to 30 and no vertex is pending.
`default_nettype none
`include "ellipse_fan_vertex_generator_defines.svh"

module ellipse_fan_vertex_generator #(
    parameter int CORDIC_STEPS = efvg_pkg::CORDIC_STEPS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,

    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [5:0]         point_count,

    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic signed [15:0] left,
    input  wire logic signed [15:0] top,
    input  wire logic [14:0]        width,
    input  wire logic [14:0]        height,

    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [5:0]              vertex_index,
    output logic signed [15:0]      pos_x,
    output logic signed [15:0]      pos_y,
    output logic                    last
);

    // The block works on one request at a time. A request transaction starts a division of
    // a full turn by the point count; its quotient and remainder then step the rim phase
    // exactly, so no divider is needed per vertex. The center is emitted first, then each
    // rim point is rotated by the CORDIC unit, scaled by the half box size on one shared
    // multiplier (x, then y) and placed in the output register. The fan closes with a copy
    // of the first rim point flagged last.
    //
    // The output register decouples the sides: a new request transaction is accepted as soon
    // as the final vertex is loaded, even while that vertex still waits for out_ready.
    // Configuration writes are always taken; they are meant to arrive while the block is idle.

    efvg_pkg::efvg_cmd_t cmd;
    efvg_pkg::efvg_sts_t sts;

    assign cfg_ready = 1'b1;

    efvg_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    efvg_datapath #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sts             (sts),
        .cfg_valid       (cfg_valid),
        .cfg_point_count (point_count),
        .in_left         (left),
        .in_top          (top),
        .in_width        (width),
        .in_height       (height),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .out_vertex_index(vertex_index),
        .out_pos_x       (pos_x),
        .out_pos_y       (pos_y),
        .out_last        (last)
    );

    // Once a request is taken the block is busy with it in the next cycle.
    `EFVG_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "accepted while busy")
    // A vertex is only loaded when the output register is empty or being drained.
    `EFVG_ASSERT_IMPL(a_no_overwrite, cmd.out_rim || cmd.out_last, sts.out_free, "vertex lost")
    // Rim and closing vertices never load in the same cycle.
    `EFVG_ASSERT_ALWAYS(a_single_load, !(cmd.out_rim && cmd.out_last), "double vertex load")
    // A fan has at least three rim points, so the closing vertex index is at least four.
    `EFVG_ASSERT_IMPL(a_last_index, out_valid && last, vertex_index >= 6'd4, "short fan")

endmodule

`default_nettype wire

// File: rtl/efvg_cordic.sv
// Iterative CORDIC rotation giving cosine and sine of a binary angle less a quarter turn, in Q4.30.
`default_nettype none

module efvg_cordic #(
    parameter int CORDIC_STEPS = efvg_pkg::CORDIC_STEPS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic [31:0]        phase,
    output logic                    done,
    output logic signed [33:0]      cos_out,
    output logic signed [33:0]      sin_out
);

    localparam int KW = $clog2(CORDIC_STEPS);
    localparam logic [KW-1:0] K_LAST = KW'(CORDIC_STEPS - 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [KW-1:0]     k_reg, k_next;
    logic signed [33:0] x_reg, x_next;
    logic signed [33:0] y_reg, y_next;
    logic signed [33:0] a_reg, a_next;
    logic              neg_reg, neg_next;

    logic [31:0]        ph;
    logic signed [33:0] a_in;
    logic signed [33:0] a_fold;
    logic               fold_neg;
    logic signed [33:0] dx;
    logic signed [33:0] dy;
    logic signed [33:0] at;

    always_comb
    begin
        ph   = phase - efvg_pkg::QUARTER_PHASE;
        a_in = $signed({{2{ph[31]}}, ph});
        if (a_in > efvg_pkg::QUARTER_TURN) begin
            a_fold   = a_in - efvg_pkg::HALF_TURN;
            fold_neg = 1'b1;
        end
        else if (a_in < -efvg_pkg::QUARTER_TURN) begin
            a_fold   = a_in + efvg_pkg::HALF_TURN;
            fold_neg = 1'b1;
        end
        else begin
            a_fold   = a_in;
            fold_neg = 1'b0;
        end

        dx = y_reg >>> k_reg;
        dy = x_reg >>> k_reg;
        at = $signed({4'b0, efvg_pkg::atan_turns(5'(k_reg))});

        busy_next = busy_reg;
        done_next = done_reg;
        k_next    = k_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        a_next    = a_reg;
        neg_next  = neg_reg;

        if (start) begin
            busy_next = 1'b1;
            done_next = 1'b0;
            k_next    = '0;
            x_next    = efvg_pkg::CORDIC_X0;
            y_next    = '0;
            a_next    = a_fold;
            neg_next  = fold_neg;
        end
        else if (busy_reg) begin
            if (!a_reg[33]) begin
                x_next = x_reg - dx;
                y_next = y_reg + dy;
                a_next = a_reg - at;
            end
            else begin
                x_next = x_reg + dx;
                y_next = y_reg - dy;
                a_next = a_reg + at;
            end
            k_next = k_reg + KW'(1);
            if (k_reg == K_LAST) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            k_reg    <= '0;
        end
        else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            k_reg    <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        y_reg   <= y_next;
        a_reg   <= a_next;
        neg_reg <= neg_next;
    end

    assign done    = done_reg;
    assign cos_out = neg_reg ? -x_reg : x_reg;
    assign sin_out = neg_reg ? -y_reg : y_reg;

endmodule

`default_nettype wire

// File: rtl/efvg_datapath.sv
// Datapath: configuration, step divider, phase accumulator, CORDIC, placement, output register.
`default_nettype none

module efvg_datapath #(
    parameter int CORDIC_STEPS = efvg_pkg::CORDIC_STEPS_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire efvg_pkg::efvg_cmd_t cmd,
    output efvg_pkg::efvg_sts_t      sts,
    input  wire logic                cfg_valid,
    input  wire logic [5:0]          cfg_point_count,
    input  wire logic signed [15:0]  in_left,
    input  wire logic signed [15:0]  in_top,
    input  wire logic [14:0]         in_width,
    input  wire logic [14:0]         in_height,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic [5:0]               out_vertex_index,
    output logic signed [15:0]       out_pos_x,
    output logic signed [15:0]       out_pos_y,
    output logic                     out_last
);

    logic [5:0] pc_reg;

    logic signed [15:0] left_reg, top_reg;
    logic [14:0]        w_reg, h_reg;
    logic [5:0]         n_reg;
    logic [5:0]         n_eff;

    logic [5:0]  div_cnt_reg;
    logic [5:0]  rem_reg, rem_next;
    logic [31:0] quo_reg;
    logic        div_bit;
    logic [6:0]  rem_sh;
    logic        div_ge;

    logic [31:0] acc_reg, acc_next;
    logic [5:0]  racc_reg, racc_next;
    logic [6:0]  rsum;
    logic        carry;

    logic [5:0] idx_reg;

    logic               cordic_done;
    logic signed [33:0] cos_v, sin_v;

    logic signed [33:0] t_sel;
    logic [14:0]        size_sel;
    logic signed [15:0] size_s;
    logic signed [49:0] prod_next, prod_reg;
    logic [15:0]        px_reg;
    logic [15:0]        py;
    logic [15:0]        fx_reg, fy_reg;

    logic        ov_reg;
    logic [5:0]  oidx_reg;
    logic [15:0] ox_reg, oy_reg;
    logic        olast_reg;
    logic        out_free;

    efvg_cordic #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_cordic (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cmd.cordic_start),
        .phase  (acc_reg),
        .done   (cordic_done),
        .cos_out(cos_v),
        .sin_out(sin_v)
    );

    always_comb
    begin
        if (pc_reg < efvg_pkg::MIN_POINTS) begin
            n_eff = efvg_pkg::MIN_POINTS;
        end
        else if (pc_reg > efvg_pkg::MAX_POINTS) begin
            n_eff = efvg_pkg::MAX_POINTS;
        end
        else begin
            n_eff = pc_reg;
        end

        // Restoring division of 2^32 by n, one quotient bit per cycle.
        div_bit = (div_cnt_reg == efvg_pkg::DIV_STEPS);
        rem_sh  = {rem_reg, div_bit};
        div_ge  = (rem_sh >= {1'b0, n_reg});
        rem_next = div_ge ? 6'(rem_sh - {1'b0, n_reg}) : rem_sh[5:0];

        // Phase of rim point i is i*q + floor(i*r/n), tracked with a running remainder.
        rsum      = {1'b0, racc_reg} + {1'b0, rem_reg};
        carry     = (rsum >= {1'b0, n_reg});
        racc_next = carry ? 6'(rsum - {1'b0, n_reg}) : rsum[5:0];
        acc_next  = acc_reg + quo_reg + {31'b0, carry};

        if (idx_reg == 6'd0) begin
            t_sel = '0;
        end
        else begin
            t_sel = cmd.mul_y ? sin_v : cos_v;
        end
        size_sel  = cmd.mul_y ? h_reg : w_reg;
        size_s    = $signed({1'b0, size_sel});
        prod_next = 50'(t_sel) * 50'(size_s);

        py = efvg_pkg::place(top_reg, h_reg, prod_reg);

        out_free = !ov_reg || out_ready;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pc_reg      <= efvg_pkg::PC_RESET;
            div_cnt_reg <= '0;
            idx_reg     <= '0;
            ov_reg      <= 1'b0;
        end
        else begin
            if (cfg_valid) begin
                pc_reg <= cfg_point_count;
            end

            if (cmd.load) begin
                div_cnt_reg <= efvg_pkg::DIV_STEPS;
            end
            else if (div_cnt_reg != 6'd0) begin
                div_cnt_reg <= div_cnt_reg - 6'd1;
            end

            if (cmd.load) begin
                idx_reg <= '0;
            end
            else if (cmd.out_rim || cmd.out_last) begin
                idx_reg <= idx_reg + 6'd1;
            end

            if (cmd.out_rim || cmd.out_last) begin
                ov_reg <= 1'b1;
            end
            else if (out_ready) begin
                ov_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load) begin
            left_reg <= in_left;
            top_reg  <= in_top;
            w_reg    <= in_width;
            h_reg    <= in_height;
            n_reg    <= n_eff;
            rem_reg  <= '0;
            quo_reg  <= '0;
            acc_reg  <= '0;
            racc_reg <= '0;
        end
        else begin
            if (div_cnt_reg != 6'd0) begin
                rem_reg <= rem_next;
                quo_reg <= {quo_reg[30:0], div_ge};
            end
            if (cmd.out_rim && (idx_reg != 6'd0)) begin
                acc_reg  <= acc_next;
                racc_reg <= racc_next;
            end
        end

        if (cmd.mul_en) begin
            prod_reg <= prod_next;
        end
        if (cmd.px_en) begin
            px_reg <= efvg_pkg::place(left_reg, w_reg, prod_reg);
        end
        if (cmd.out_rim && (idx_reg == 6'd1)) begin
            fx_reg <= px_reg;
            fy_reg <= py;
        end

        if (cmd.out_rim) begin
            oidx_reg  <= idx_reg;
            ox_reg    <= px_reg;
            oy_reg    <= py;
            olast_reg <= 1'b0;
        end
        else if (cmd.out_last) begin
            oidx_reg  <= idx_reg;
            ox_reg    <= fx_reg;
            oy_reg    <= fy_reg;
            olast_reg <= 1'b1;
        end
    end

    always_comb
    begin
        sts.div_done     = (div_cnt_reg == 6'd0);
        sts.cordic_done  = cordic_done;
        sts.out_free     = out_free;
        sts.idx_last_rim = (idx_reg == n_reg);
    end

    assign out_valid        = ov_reg;
    assign out_vertex_index = oidx_reg;
    assign out_pos_x        = ox_reg;
    assign out_pos_y        = oy_reg;
    assign out_last         = olast_reg;

endmodule

`default_nettype wire

// File: rtl/efvg_ctrl.sv
// Controller state machine sequencing one fan request through the datapath.
`default_nettype none

module efvg_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire efvg_pkg::efvg_sts_t sts,
    output efvg_pkg::efvg_cmd_t      cmd
);

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_DIV   = 8'b0000_0010,
        ST_START = 8'b0000_0100,
        ST_ROT   = 8'b0000_1000,
        ST_MULX  = 8'b0001_0000,
        ST_MULY  = 8'b0010_0000,
        ST_EMIT  = 8'b0100_0000,
        ST_LAST  = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (sts.div_done) begin
                    state_next = ST_MULX;
                end
            end
            ST_START: begin
                cmd.cordic_start = 1'b1;
                state_next       = ST_ROT;
            end
            ST_ROT: begin
                if (sts.cordic_done) begin
                    state_next = ST_MULX;
                end
            end
            ST_MULX: begin
                cmd.mul_en = 1'b1;
                state_next = ST_MULY;
            end
            ST_MULY: begin
                cmd.px_en  = 1'b1;
                cmd.mul_en = 1'b1;
                cmd.mul_y  = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (sts.out_free) begin
                    cmd.out_rim = 1'b1;
                    if (sts.idx_last_rim) begin
                        state_next = ST_LAST;
                    end
                    else begin
                        state_next = ST_START;
                    end
                end
            end
            ST_LAST: begin
                if (sts.out_free) begin
                    cmd.out_last = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= ST_IDLE;
        end
        else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire
